// File: src/mtg_pkg.sv
package mtg_pkg;

  localparam int TABLE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int MAX_BURST     = 64;

  localparam int POS_W = $clog2(TABLE_WORDS);
  localparam int CNT_W = $clog2(MAX_BURST + 1);

  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] TWIST_XOR  = 32'h9908B0DF;
  localparam logic [31:0] UPPER_BIT  = 32'h80000000;
  localparam logic [31:0] LOWER_BITS = 32'h7FFFFFFF;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic       opcode;
    logic [6:0] word_count;
  } req_t;

  typedef struct packed {
    logic [31:0] random_word;
    logic        last_word;
  } rsp_t;

  typedef enum logic {
    OP_GENERATE = 1'b0,
    OP_RESEED   = 1'b1
  } opcode_t;

  function automatic logic [31:0] twiddle(input logic [31:0] u, input logic [31:0] v);
    logic [31:0] mix;
    mix = (u & UPPER_BIT) | (v & LOWER_BITS);
    return (mix >> 1) ^ (v[0] ? TWIST_XOR : 32'd0);
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] x_in);
    logic [31:0] x;
    x = x_in;
    x = x ^ (x >> 11);
    x = x ^ ((x << 7) & 32'h9D2C5680);
    x = x ^ ((x << 15) & 32'hEFC60000);
    x = x ^ (x >> 18);
    return x;
  endfunction

  // (p + off) mod TABLE_WORDS for p < TABLE_WORDS, off < TABLE_WORDS
  function automatic pos_t wrap_add(input pos_t p, input pos_t off);
    logic [POS_W:0] sum;
    sum = {1'b0, p} + {1'b0, off};
    if (sum >= (POS_W+1)'(TABLE_WORDS)) begin
      sum = sum - (POS_W+1)'(TABLE_WORDS);
    end
    return sum[POS_W-1:0];
  endfunction

endpackage

// File: src/mersenne_twister_generator_core.sv
// Channel | Dir | Handshake            | Payload
// req     | in  | req_valid/req_ready  | req_t: opcode, word_count
// rsp     | out | rsp_valid/rsp_ready  | rsp_t: random_word, last_word
// cfg     | in  | cfg_valid/cfg_ready  | cfg_data: seed
//
// A reseed walks the table at one entry per cycle, set by the
// serial seed recurrence (one multiply per entry) and the single write port.
// Words then leave at one per cycle while rsp is not stalled, up to
// min(word_count,64) words per request, and the block then returns to idle.
// Sync reset; the table holds garbage until the first request reseeds it.
// A stalled rsp holds the pipeline; the two-read-port RAM is re-read each cycle.
module mersenne_twister_generator_core
  import mtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SEED = 3'b010,
    ST_RUN  = 3'b100
  } state_t;

  state_t      state;
  logic [31:0] seed_value;
  logic        table_seeded;
  pos_t        pos;
  cnt_t        cnt;
  logic [31:0] cur;
  pos_t        seed_idx;
  logic [31:0] seed_word;

  logic        req_fire;
  logic        advance;
  pos_t        pos_inc;
  pos_t        pos_sel;
  pos_t        raddr_a;
  pos_t        raddr_b;
  logic [31:0] rdata_a;
  logic [31:0] rdata_b;
  logic        ram_we;
  pos_t        ram_waddr;
  logic [31:0] ram_wdata;
  logic [31:0] seed_mix;
  logic [31:0] seed_prod;
  logic [31:0] seed_next;
  cnt_t        burst;

  assign cfg_ready = 1'b1;
  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;

  assign burst = (req.word_count > 7'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                  : CNT_W'(req.word_count);

  assign advance = (state == ST_RUN) && (cnt != '0) && (!rsp_valid || rsp_ready);

  // Reads track the position of the next cycle, so rdata always holds
  // t[pos+1] and t[pos+397]. Writes land at pos, never at those addresses.
  assign pos_inc = wrap_add(pos, POS_W'(1));
  assign pos_sel = advance ? pos_inc : pos;
  assign raddr_a = wrap_add(pos_sel, POS_W'(1));
  assign raddr_b = wrap_add(pos_sel, POS_W'(MIDDLE_OFFSET));

  assign seed_mix  = seed_word ^ (seed_word >> 30);
  assign seed_prod = INIT_MULT * seed_mix;
  assign seed_next = seed_prod + 32'(seed_idx) + 32'd1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = rdata_b ^ twiddle(cur, rdata_a);
    if (state == ST_SEED) begin
      ram_we    = 1'b1;
      ram_waddr = seed_idx;
      ram_wdata = seed_word;
    end else if (advance) begin
      ram_we = 1'b1;
    end
  end

  mtg_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_WORDS)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      seed_value   <= 32'd5489;
      table_seeded <= 1'b0;
      pos          <= '0;
      cnt          <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        seed_value <= cfg_data;
      end

      if (rsp_valid && rsp_ready && !advance) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            cnt <= burst;
            if (req.opcode == OP_RESEED || !table_seeded) begin
              state <= ST_SEED;
              pos   <= '0;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_SEED: begin
          if (seed_idx == POS_W'(TABLE_WORDS - 1)) begin
            state        <= ST_RUN;
            table_seeded <= 1'b1;
          end
        end
        ST_RUN: begin
          if (cnt == '0) begin
            state <= ST_IDLE;
          end else if (advance) begin
            rsp_valid <= 1'b1;
            pos       <= pos_inc;
            cnt       <= cnt - CNT_W'(1);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_fire) begin
      seed_idx  <= '0;
      seed_word <= seed_value;
      if (req.opcode == OP_RESEED || !table_seeded) begin
        cur <= seed_value;
      end
    end else if (state == ST_SEED) begin
      seed_idx  <= seed_idx + POS_W'(1);
      seed_word <= seed_next;
    end
    if (advance) begin
      cur             <= rdata_a;
      rsp.random_word <= temper(cur);
      rsp.last_word   <= (cnt == CNT_W'(1));
    end
  end

endmodule

// File: src/mtg_ram.sv
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import mtg_pkg::*;

  localparam int SEED_SHIFT   = 30;
  localparam int IDLE_PCT     = 18;
  localparam int SETTLE_CYCLES = TABLE_WORDS + MAX_BURST + 8;
  localparam int STALL_LIMIT  = 4000;
  localparam logic [31:0] RESET_SEED = 32'd5489;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // generator state as the block should hold it
  logic [31:0] mt_table [TABLE_WORDS];
  int          mt_pos;
  bit          mt_seeded;
  logic [31:0] seed_reg;

  rsp_t        expected_words[$];
  rsp_t        want_word;
  int          mismatch_count;
  int          idle_cycles;
  bit          no_stall;

  mersenne_twister_generator_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] temper_word(input logic [31:0] v);
    logic [31:0] y;
    y = v ^ {11'b0, v[31:11]};
    y = y ^ ({y[24:0], 7'b0} & 32'h9D2C5680);
    y = y ^ ({y[16:0], 15'b0} & 32'hEFC60000);
    return y ^ {18'b0, y[31:18]};
  endfunction

  function automatic logic [31:0] twist_word(input logic [31:0] cur, input logic [31:0] nxt,
                                             input logic [31:0] mid);
    logic [31:0] joined;
    joined = {cur[31], nxt[30:0]};
    return mid ^ {1'b0, joined[31:1]} ^ (nxt[0] ? TWIST_XOR : 32'd0);
  endfunction

  // expected words of one request; the table is twisted in place as words leave
  task automatic predict_burst(input opcode_t op, input logic [6:0] count);
    int          n;
    int          nxt;
    logic [31:0] prev;
    logic [31:0] cur;
    rsp_t        w;
    if (op == OP_RESEED || !mt_seeded) begin
      mt_table[0] = seed_reg;
      for (int i = 1; i < TABLE_WORDS; i++) begin
        prev = mt_table[i-1];
        mt_table[i] = INIT_MULT * (prev ^ (prev >> SEED_SHIFT)) + 32'(i);
      end
      mt_pos = 0;
      mt_seeded = 1'b1;
    end
    n = (count > MAX_BURST) ? MAX_BURST : int'(count);
    for (int k = 0; k < n; k++) begin
      nxt = (mt_pos + 1) % TABLE_WORDS;
      cur = mt_table[mt_pos];
      w.random_word = temper_word(cur);
      w.last_word = (k == n - 1);
      expected_words.push_back(w);
      mt_table[mt_pos] = twist_word(cur, mt_table[nxt],
                                    mt_table[(mt_pos + MIDDLE_OFFSET) % TABLE_WORDS]);
      mt_pos = nxt;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // returns at the accepting edge with req_valid still high
  task automatic send_request(input opcode_t op, input logic [6:0] count);
    while (!no_stall && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= '{opcode: op, word_count: count};
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    predict_burst(op, count);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    seed_reg = value;
    cfg_valid <= 1'b0;
  endtask

  // zero-count requests leave no trace in the queue, so settle for a full reseed after
  task automatic drain_results();
    req_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_first_request_reseeds();
    // generate-only opcode, but the table is unseeded: reset seed applies
    send_request(OP_GENERATE, 7'd5);
    send_request(OP_GENERATE, 7'd3);
  endtask

  task automatic test_count_edges();
    send_request(OP_GENERATE, 7'd0);
    send_request(OP_GENERATE, 7'd1);
    send_request(OP_GENERATE, 7'd64);
    send_request(OP_GENERATE, 7'd65);
    send_request(OP_GENERATE, 7'd127);
    send_request(OP_RESEED, 7'd0);
    send_request(OP_GENERATE, 7'd3);
  endtask

  task automatic test_seed_extremes();
    drain_results();
    write_seed(32'h0000_0000);
    send_request(OP_RESEED, 7'd4);
    drain_results();
    write_seed(32'hFFFF_FFFF);
    send_request(OP_RESEED, 7'd4);
    send_request(OP_GENERATE, 7'd2);
  endtask

  task automatic test_table_wraparound();
    drain_results();
    write_seed($urandom);
    send_request(OP_RESEED, 7'd64);
    // 11 x 64 words cross the end of the table and reuse twisted entries
    for (int i = 0; i < 10; i++) send_request(OP_GENERATE, 7'd64);
  endtask

  task automatic test_random_bursts(input int n_items);
    opcode_t    op;
    logic [6:0] count;
    int         r;
    for (int i = 0; i < n_items; i++) begin
      if (i % 73 == 72) begin
        drain_results();
        write_seed(pick_seed());
      end
      no_stall = (i >= 150 && i < 210);
      op = ($urandom_range(99) < 10) ? OP_RESEED : OP_GENERATE;
      r = $urandom_range(99);
      if (r < 5) count = 7'd0;
      else if (r < 13) count = 7'($urandom_range(127, MAX_BURST + 1));
      else count = 7'($urandom_range(MAX_BURST, 1));
      if (!no_stall && expected_words.size() != 0 && $urandom_range(99) < 3) begin
        // hold off until the block has handed over everything
        req_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
      end
      send_request(op, count);
    end
    no_stall = 1'b0;
  endtask

  always @(posedge clk) begin
    rsp_ready <= no_stall || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h last %b", rsp.random_word,
                                  rsp.last_word));
      end else begin
        want_word = expected_words.pop_front();
        if (rsp.random_word !== want_word.random_word)
          report_mismatch($sformatf("random_word %h, expected %h", rsp.random_word,
                                    want_word.random_word));
        if (rsp.last_word !== want_word.last_word)
          report_mismatch($sformatf("last_word %b, expected %b on word %h", rsp.last_word,
                                    want_word.last_word, want_word.random_word));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    mismatch_count = 0;
    idle_cycles = 0;
    no_stall = 1'b0;
    mt_pos = 0;
    mt_seeded = 1'b0;
    seed_reg = RESET_SEED;
    foreach (mt_table[i]) mt_table[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_first_request_reseeds();
    test_count_edges();
    test_seed_extremes();
    test_table_wraparound();
    test_random_bursts(438);
    drain_results();

    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", expected_words.size()));
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
